// File: rtl/xor_key_base64_codec_defines.svh
// ----------------------------------------------------------------------------
// xor_key_base64_codec_defines
// Assertion macros used by the codec top level.
// ----------------------------------------------------------------------------
`ifndef XOR_KEY_BASE64_CODEC_DEFINES_SVH
`define XOR_KEY_BASE64_CODEC_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define XKB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xkb64 same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define XKB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xkb64 next-cycle check failed");

`endif

// File: rtl/xkb64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xkb64_pkg
// Types, constants and Base64 alphabet helpers for the XOR/Base64 codec.
// ----------------------------------------------------------------------------
package xkb64_pkg;

   localparam int KEY_MAX_BYTES = 8;
   localparam int KEY_BITS      = KEY_MAX_BYTES * 8;
   localparam int KEY_POS_W     = $clog2(KEY_MAX_BYTES);
   localparam int KEY_LEN_W     = 4;
   localparam int ACC_W         = 16;
   localparam int PEND_W        = 5;
   localparam int MAX_RESULTS   = 4;
   localparam int RES_IDX_W     = $clog2(MAX_RESULTS);
   localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 64;

   localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

   localparam logic DIR_ENCRYPT = 1'b0;
   localparam logic DIR_DECRYPT = 1'b1;

   localparam logic [1:0] CSR_DIRECTION  = 2'd0;
   localparam logic [1:0] CSR_KEY_BYTES  = 2'd1;
   localparam logic [1:0] CSR_KEY_LENGTH = 2'd2;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       marker_only;
   } result_type;

   typedef result_type [MAX_RESULTS-1:0] result_vec_type;

   typedef struct packed {
      logic [ACC_W-1:0]     bit_acc;
      logic [PEND_W-1:0]    pend_bits;   // two's complement
      logic [1:0]           chars_mod4;
      logic [KEY_POS_W-1:0] key_pos;
      logic                 decode_stopped;
   } msg_state_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } b64_val_type;

   function automatic msg_state_type msg_restart(input logic dir);
      msg_state_type s;
      s                = '0;
      s.pend_bits      = (dir == DIR_DECRYPT) ? 5'b11000 : 5'b11010;  // -8 / -6
      return s;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] idx);
      logic [7:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26)      return 8'(wide + 8'd65);
      else if (idx < 6'd52) return 8'(wide + 8'd71);
      else if (idx < 6'd62) return 8'(wide - 8'd4);
      else if (idx == 6'd62) return 8'h2B;
      else                  return 8'h2F;
   endfunction

   function automatic b64_val_type b64_decode(input logic [7:0] c);
      b64_val_type r;
      r = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.valid = 1'b1;
         r.value = 6'(c - 8'd65);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.valid = 1'b1;
         r.value = 6'(c - 8'd71);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.valid = 1'b1;
         r.value = 6'(c + 8'd4);
      end else if (c == 8'h2B) begin
         r.valid = 1'b1;
         r.value = 6'd62;
      end else if (c == 8'h2F) begin
         r.valid = 1'b1;
         r.value = 6'd63;
      end
      return r;
   endfunction

endpackage

// File: rtl/xkb64_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xkb64_req_if
// Input channel: one message byte per transaction with an end flag.
// ----------------------------------------------------------------------------
interface xkb64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/xkb64_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xkb64_rsp_if
// Result channel: one output byte or end marker per transaction.
// ----------------------------------------------------------------------------
interface xkb64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       marker_only;

   modport source (output valid, output out_byte, output out_last, output marker_only,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input marker_only,
                   output ready);
endinterface

// File: rtl/xkb64_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xkb64_core
// Single-pass datapath: one byte plus message state in, up to four results
// and the next message state out.
// ----------------------------------------------------------------------------
module xkb64_core (
   input  logic                                direction,
   input  logic [xkb64_pkg::KEY_BITS-1:0]      key_bytes,
   input  logic [xkb64_pkg::KEY_LEN_W-1:0]     key_length,
   input  xkb64_pkg::msg_state_type            state_cur,
   input  logic [7:0]                          in_byte,
   input  logic                                in_last,
   output xkb64_pkg::result_vec_type           results,
   output logic [xkb64_pkg::CNT_W-1:0]         result_cnt,
   output xkb64_pkg::msg_state_type            state_nxt
);
   import xkb64_pkg::*;

   // key selection
   logic [KEY_LEN_W-1:0] used_len;
   logic [KEY_POS_W-1:0] key_pos_use;
   logic [KEY_LEN_W-1:0] key_pos_inc;
   logic [KEY_POS_W-1:0] key_pos_adv;
   logic [7:0]           key_byte;

   // encrypt path
   logic [7:0]               enc_x;
   logic [ACC_W-1:0]         enc_acc;
   logic signed [PEND_W-1:0] enc_pend1;
   logic signed [PEND_W-1:0] enc_pend2;
   logic signed [PEND_W-1:0] enc_pend3;
   logic                     ch0_v;
   logic                     ch1_v;
   logic                     flush_v;
   logic [3:0]               flush_sh;
   logic [5:0]               chars [MAX_RESULTS];
   logic [1:0]               k_main;
   logic [1:0]               k_all;
   logic [1:0]               cmf_after;
   logic [1:0]               pads;
   logic [CNT_W-1:0]         enc_total;
   logic [CNT_W-1:0]         enc_cnt;

   // decrypt path
   b64_val_type              dec_cv;
   logic [ACC_W-1:0]         dec_acc;
   logic signed [PEND_W-1:0] dec_pend1;
   logic                     dec_active;
   logic                     dec_emit;
   logic [7:0]               dec_d;

   logic [RES_IDX_W-1:0]     last_idx;

   assign used_len    = (key_length > KEY_LEN_W'(KEY_MAX_BYTES)) ?
                        KEY_LEN_W'(KEY_MAX_BYTES) : key_length;
   // stale position falls back to key byte 0
   assign key_pos_use = (KEY_LEN_W'(state_cur.key_pos) < used_len) ?
                        state_cur.key_pos : '0;
   assign key_pos_inc = KEY_LEN_W'(key_pos_use) + KEY_LEN_W'(1);
   assign key_pos_adv = (key_pos_inc >= used_len) ? '0 : KEY_POS_W'(key_pos_inc);
   assign key_byte    = key_bytes[{key_pos_use, 3'b000} +: 8];

   // ---- encrypt: XOR, append 8 bits, emit whole sextets, flush on the last byte
   assign enc_x     = in_byte ^ key_byte;
   assign enc_acc   = {state_cur.bit_acc[ACC_W-9:0], enc_x};
   assign enc_pend1 = $signed(state_cur.pend_bits) + 5'sd8;
   assign ch0_v     = !enc_pend1[PEND_W-1];
   assign enc_pend2 = enc_pend1 - 5'sd6;
   assign ch1_v     = ch0_v && !enc_pend2[PEND_W-1];
   assign enc_pend3 = ch1_v ? (enc_pend2 - 5'sd6) : (ch0_v ? enc_pend2 : enc_pend1);
   assign flush_v   = in_last && (enc_pend3 > -5'sd6) && (enc_pend3 < 5'sd0);
   assign flush_sh  = 4'(enc_pend3 + 5'sd8);
   assign k_main    = 2'(ch0_v) + 2'(ch1_v);
   assign k_all     = k_main + 2'(flush_v);
   assign cmf_after = state_cur.chars_mod4 + k_all;
   assign pads      = in_last ? (2'd0 - cmf_after) : 2'd0;
   assign enc_total = CNT_W'(k_all) + CNT_W'(pads);
   assign enc_cnt   = (enc_total > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : enc_total;

   always_comb begin
      chars[0] = 6'(enc_acc >> enc_pend1[2:0]);
      chars[1] = 6'(enc_acc >> enc_pend2[2:0]);
      chars[2] = '0;
      chars[3] = '0;
      // leftover bits go left-aligned, zero-filled, right after the full sextets
      if (flush_v) begin
         chars[k_main] = 6'({enc_acc, 8'h00} >> flush_sh);
      end
   end

   // ---- decrypt: append 6 bits, emit a byte once 8 are pending
   assign dec_cv     = b64_decode(in_byte);
   assign dec_active = !state_cur.decode_stopped;
   assign dec_acc    = {state_cur.bit_acc[ACC_W-7:0], dec_cv.value};
   assign dec_pend1  = $signed(state_cur.pend_bits) + 5'sd6;
   assign dec_emit   = dec_active && dec_cv.valid && !dec_pend1[PEND_W-1];
   assign dec_d      = 8'(dec_acc >> dec_pend1[2:0]);

   always_comb begin
      results    = '0;
      result_cnt = '0;
      state_nxt  = state_cur;
      last_idx   = '0;

      if (used_len == '0) begin
         results[0].out_byte = in_byte;
         result_cnt          = CNT_W'(1);
      end else if (direction == DIR_ENCRYPT) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (CNT_W'(i) < CNT_W'(k_all)) begin
               results[i].out_byte = b64_char(chars[i]);
            end else begin
               results[i].out_byte = PAD_CHAR;
            end
         end
         result_cnt           = enc_cnt;
         state_nxt.bit_acc    = enc_acc;
         state_nxt.pend_bits  = enc_pend3;
         state_nxt.chars_mod4 = state_cur.chars_mod4 + k_main;
         state_nxt.key_pos    = key_pos_adv;
      end else begin
         if (dec_active && !dec_cv.valid) begin
            state_nxt.decode_stopped = 1'b1;
         end else if (dec_active) begin
            state_nxt.bit_acc   = dec_acc;
            state_nxt.pend_bits = dec_emit ? PEND_W'(dec_pend1 - 5'sd8) : dec_pend1;
            if (dec_emit) begin
               results[0].out_byte = dec_d ^ key_byte;
               result_cnt          = CNT_W'(1);
               state_nxt.key_pos   = key_pos_adv;
            end
         end
      end

      if (in_last) begin
         if (result_cnt == '0) begin
            results[0].out_byte    = '0;
            results[0].out_last    = 1'b1;
            results[0].marker_only = 1'b1;
            result_cnt             = CNT_W'(1);
         end else begin
            last_idx                  = RES_IDX_W'(result_cnt - CNT_W'(1));
            results[last_idx].out_last = 1'b1;
         end
         state_nxt = msg_restart(direction);
      end
   end

endmodule

// File: rtl/xor_key_base64_codec.sv
`timescale 1ns / 1ps
`include "xor_key_base64_codec_defines.svh"
// ----------------------------------------------------------------------------
// xor_key_base64_codec
// Repeating-key XOR with Base64 encode (encrypt) or decode (decrypt).
// ----------------------------------------------------------------------------
// A byte accepted on req_chan is held in an input register, run through the
// combinational codec datapath, and its results (up to four) are parked in a
// four-entry burst buffer that feeds the rsp_chan output register one result
// per cycle while rsp_chan is not stalled. Each result passes from the input
// register through the burst buffer into the output register. The single
// result port sets the throughput: decrypt and pass-through give at most one
// result per byte, encrypt one per Base64 character (one or two per byte, and
// up to four with flush and '=' padding on the last byte of a message). A new
// byte is taken while the final result of the previous one is still being
// handed off. Registers sit at byte address 8*i: direction at 0, key bytes at
// 8, key length at 16; writing direction restarts the message.
// ----------------------------------------------------------------------------
module xor_key_base64_codec (
   input  logic                                 clock,
   input  logic                                 reset,
   xkb64_req_if.sink                            req_chan,
   xkb64_rsp_if.source                          rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [xkb64_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [xkb64_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [xkb64_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import xkb64_pkg::*;

   // configuration
   logic                 direction_ff;
   logic [KEY_BITS-1:0]  key_bytes_ff;
   logic [KEY_LEN_W-1:0] key_length_ff;
   logic                 csr_wr;
   logic [1:0]           csr_idx;

   // message state
   msg_state_type        state_ff;
   msg_state_type        state_in;

   // input register
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 req_take;

   // burst buffer
   result_type           burst_ff [MAX_RESULTS];
   logic [CNT_W-1:0]     burst_cnt_ff;
   logic [RES_IDX_W-1:0] burst_idx_ff;
   result_vec_type       core_results;
   logic [CNT_W-1:0]     core_cnt;
   logic                 burst_pop;
   logic                 burst_done;
   logic                 in_move;
   logic                 dec_move;

   // output register
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;
   logic                 out_free;

   xkb64_core u_core (
      .direction  (direction_ff),
      .key_bytes  (key_bytes_ff),
      .key_length (key_length_ff),
      .state_cur  (state_ff),
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .results    (core_results),
      .result_cnt (core_cnt),
      .state_nxt  (state_in)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:3];

   always_comb begin
      unique case (csr_idx)
         CSR_DIRECTION:  csr_prdata = CSR_DATA_W'(direction_ff);
         CSR_KEY_BYTES:  csr_prdata = CSR_DATA_W'(key_bytes_ff);
         CSR_KEY_LENGTH: csr_prdata = CSR_DATA_W'(key_length_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign burst_pop  = (burst_cnt_ff != '0) && out_free;
   // burst is empty or empties this cycle: the next item may load it
   assign burst_done = (burst_cnt_ff == '0) || ((burst_cnt_ff == CNT_W'(1)) && burst_pop);
   assign in_move    = in_valid_ff && burst_done;
   assign dec_move   = in_move && (direction_ff == DIR_DECRYPT);

   assign req_chan.ready = !in_valid_ff || in_move;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_data_ff.out_byte;
   assign rsp_chan.out_last    = rsp_data_ff.out_last;
   assign rsp_chan.marker_only = rsp_data_ff.marker_only;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff  <= DIR_ENCRYPT;
         key_bytes_ff  <= '0;
         key_length_ff <= '0;
         state_ff      <= msg_restart(DIR_ENCRYPT);
         in_valid_ff   <= 1'b0;
         burst_cnt_ff  <= '0;
         burst_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_idx)
               CSR_DIRECTION:  direction_ff  <= csr_pwdata[0];
               CSR_KEY_BYTES:  key_bytes_ff  <= csr_pwdata;
               CSR_KEY_LENGTH: key_length_ff <= csr_pwdata[KEY_LEN_W-1:0];
               default: ;
            endcase
         end

         // direction write restarts the message; key writes keep the position
         if (csr_wr && (csr_idx == CSR_DIRECTION)) begin
            state_ff <= msg_restart(csr_pwdata[0]);
         end else if (in_move) begin
            state_ff <= state_in;
         end

         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (in_move) begin
            in_valid_ff <= 1'b0;
         end

         if (in_move) begin
            burst_cnt_ff <= core_cnt;
            burst_idx_ff <= '0;
         end else if (burst_pop) begin
            burst_cnt_ff <= burst_cnt_ff - CNT_W'(1);
            burst_idx_ff <= burst_idx_ff + RES_IDX_W'(1);
         end

         if (out_free) begin
            rsp_valid_ff <= burst_pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.in_last;
      end
      if (in_move) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            burst_ff[i] <= core_results[i];
         end
      end
      if (burst_pop) begin
         rsp_data_ff <= burst_ff[burst_idx_ff];
      end
   end

   `XKB_ASSERT_NOW(a_burst_bound, clock, reset, 1'b1, burst_cnt_ff <= CNT_W'(MAX_RESULTS))
   `XKB_ASSERT_NEXT(a_in_capture, clock, reset, req_take, in_valid_ff)
   `XKB_ASSERT_NEXT(a_dec_single, clock, reset, dec_move, burst_cnt_ff <= CNT_W'(1))

endmodule
